// ----- hw/rtl/lifee_pkg.sv -----
// shared types and constants for the leaky integrate-and-fire layer
package lifee_pkg;

    localparam int CUR_W  = 16;
    localparam int CH_W   = 8;
    localparam int MEM_W  = 24;
    localparam int THR_W  = 15;
    localparam int LEAK_W = 16;
    localparam int CNT_W  = 9;
    localparam int DIST_W = 15;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [THR_W-1:0]  FIRE_THR_RST = THR_W'(128);
    localparam logic [LEAK_W-1:0] LEAK_RST     = LEAK_W'(49152);
    localparam logic [THR_W-1:0]  EXIT_THR_RST = '0;

    typedef enum logic [IDX_W-1:0] {
        REG_FIRE_THR = 2'd0,
        REG_LEAK     = 2'd1,
        REG_EXIT_THR = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [MEM_W-1:0] mem;
        logic                    spike;
    } upd_t;

endpackage

// ----- hw/rtl/lifee_ram.sv -----
// generic simple dual-port ram with registered read
module lifee_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/lifee_update.sv -----
// membrane decay, integration, saturation and soft-reset firing
module lifee_update (
    input  logic signed [lifee_pkg::MEM_W-1:0]  mem_old,
    input  logic signed [lifee_pkg::CUR_W-1:0]  current,
    input  logic        [lifee_pkg::LEAK_W-1:0] leak_factor,
    input  logic        [lifee_pkg::THR_W-1:0]  fire_threshold,
    output lifee_pkg::upd_t                     upd
);
    import lifee_pkg::*;

    localparam int PROD_W  = MEM_W + LEAK_W + 1;
    localparam int DECAY_W = PROD_W - 16;
    localparam int SUM_W   = DECAY_W + 1;

    logic signed [PROD_W-1:0]  prod;
    logic signed [DECAY_W-1:0] decayed;
    logic signed [SUM_W-1:0]   sum;
    logic signed [MEM_W-1:0]   sat;
    logic signed [MEM_W-1:0]   thr_ext;
    logic signed [SUM_W-1:0]   mem_max;
    logic signed [SUM_W-1:0]   mem_min;

    always_comb begin
        mem_max = SUM_W'({1'b0, {(MEM_W-1){1'b1}}});
        mem_min = -SUM_W'({1'b1, {(MEM_W-1){1'b0}}});
        prod    = PROD_W'(mem_old) * $signed({1'b0, leak_factor});
        // arithmetic shift gives floor
        decayed = DECAY_W'(prod >>> 16);
        sum     = SUM_W'(decayed) + SUM_W'(current);
        if (sum > mem_max) begin
            sat = mem_max[MEM_W-1:0];
        end else if (sum < mem_min) begin
            sat = mem_min[MEM_W-1:0];
        end else begin
            sat = sum[MEM_W-1:0];
        end
        thr_ext = $signed({{(MEM_W-THR_W){1'b0}}, fire_threshold});
        if (sat > thr_ext) begin
            upd.mem   = sat - thr_ext;
            upd.spike = 1'b1;
        end else begin
            upd.mem   = sat;
            upd.spike = 1'b0;
        end
    end

endmodule

// ----- hw/rtl/lif_neuron_layer_early_exit_top.sv -----
// top level of the leaky integrate-and-fire layer with early-exit measure
//
// One item per channel and time step, one result item per input item. An item
// is taken in every cycle while results are taken: it is registered along with
// a read of its channel's membrane, updated combinationally from that register
// (one 24x17 multiply, add, saturate, threshold) and written to the result
// register once that is free, so the throughput is one item per clock. A membrane
// written in one cycle and read for the same channel in that cycle is
// forwarded. After reset a clearing pass zeroes the membrane memory, one entry
// per cycle over all min(CHANNELS, 256) entries, during which s_ready stays low;
// configuration writes are taken throughout and apply to updates made after them.
module lif_neuron_layer_early_exit_top #(
    parameter int CHANNELS = 256
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   cfg_wr_en,
    input  logic [lifee_pkg::IDX_W-1:0]            cfg_index,
    input  logic [lifee_pkg::CFG_W-1:0]            cfg_wr_data,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [lifee_pkg::CUR_W-1:0]     s_current,
    input  logic [lifee_pkg::CH_W-1:0]             s_channel,
    input  logic                                   s_first_step,
    input  logic                                   s_last_channel,
    input  logic                                   s_last_step,
    input  logic [lifee_pkg::CNT_W-1:0]            s_prev_count,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_spike,
    output logic [lifee_pkg::CNT_W-1:0]            m_step_count,
    output logic                                   m_step_done,
    output logic                                   m_sequence_done,
    output logic                                   m_exit_flag
);
    import lifee_pkg::*;

    localparam int MEM_DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

    // configuration
    logic [THR_W-1:0]  fire_thr_reg;
    logic [LEAK_W-1:0] leak_reg;
    logic [THR_W-1:0]  exit_thr_reg;

    // clearing pass
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // update stage
    logic                    a_valid_reg;
    logic signed [CUR_W-1:0] a_current_reg;
    logic                    a_in_range_reg;
    logic [ADDR_W-1:0]       a_addr_reg;
    logic                    a_first_reg;
    logic                    a_lastc_reg;
    logic                    a_lasts_reg;
    logic [CNT_W-1:0]        a_prev_reg;
    logic                    a_fwd_reg;
    logic signed [MEM_W-1:0] a_fwd_mem_reg;

    // step state
    logic [CNT_W-1:0]  running_count_reg;
    logic [CNT_W-1:0]  running_count_next;
    logic [DIST_W-1:0] distance_reg;
    logic [DIST_W-1:0] distance_next;

    // result register
    logic             m_valid_reg;
    logic             m_spike_reg;
    logic [CNT_W-1:0] m_count_reg;
    logic             m_step_done_reg;
    logic             m_seq_done_reg;
    logic             m_exit_reg;

    logic                    s_accept;
    logic                    a_adv;
    logic                    s_in_range;
    logic [ADDR_W-1:0]       s_addr;
    logic                    ram_wr_en;
    logic [ADDR_W-1:0]       ram_wr_addr;
    logic [MEM_W-1:0]        ram_wr_data;
    logic [MEM_W-1:0]        ram_rd_data;
    logic signed [MEM_W-1:0] mem_old;
    upd_t                    upd;
    logic [CNT_W:0]          cnt_sum;
    logic [CNT_W-1:0]        count;
    logic [CNT_W-1:0]        diff;
    logic [DIST_W:0]         dist_sum;
    logic                    exit_flag;

    assign a_adv      = a_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !clearing_reg && (!a_valid_reg || a_adv);
    assign s_accept   = s_valid && s_ready;
    assign s_in_range = 32'(s_channel) < CHANNELS;
    assign s_addr     = s_channel[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fire_thr_reg <= FIRE_THR_RST;
            leak_reg     <= LEAK_RST;
            exit_thr_reg <= EXIT_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FIRE_THR: fire_thr_reg <= cfg_wr_data[THR_W-1:0];
                REG_LEAK:     leak_reg     <= cfg_wr_data[LEAK_W-1:0];
                REG_EXIT_THR: exit_thr_reg <= cfg_wr_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == CLR_LAST) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign ram_wr_en   = clearing_reg || (a_adv && a_in_range_reg);
    assign ram_wr_addr = clearing_reg ? clr_cnt_reg : a_addr_reg;
    assign ram_wr_data = clearing_reg ? '0 : upd.mem;

    lifee_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MEM_DEPTH)
    ) u_membrane (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (s_accept),
        .rd_addr (s_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_fwd_reg   <= 1'b0;
        end else if (s_accept) begin
            a_valid_reg <= 1'b1;
            // same-channel write at this edge: the ram read returns stale data
            a_fwd_reg   <= a_adv && a_in_range_reg && s_in_range && (s_addr == a_addr_reg);
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
            a_fwd_reg   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_current_reg  <= s_current;
            a_in_range_reg <= s_in_range;
            a_addr_reg     <= s_addr;
            a_first_reg    <= s_first_step;
            a_lastc_reg    <= s_last_channel;
            a_lasts_reg    <= s_last_step;
            a_prev_reg     <= s_prev_count;
            a_fwd_mem_reg  <= upd.mem;
        end
    end

    always_comb begin
        if (!a_in_range_reg || a_first_reg) begin
            mem_old = '0;
        end else if (a_fwd_reg) begin
            mem_old = a_fwd_mem_reg;
        end else begin
            mem_old = $signed(ram_rd_data);
        end
    end

    lifee_update u_update (
        .mem_old        (mem_old),
        .current        (a_current_reg),
        .leak_factor    (leak_reg),
        .fire_threshold (fire_thr_reg),
        .upd            (upd)
    );

    always_comb begin
        cnt_sum = {1'b0, running_count_reg} + (CNT_W+1)'(upd.spike);
        count   = cnt_sum[CNT_W] ? CNT_MAX : cnt_sum[CNT_W-1:0];
        diff    = (count >= a_prev_reg) ? (count - a_prev_reg) : (a_prev_reg - count);
        dist_sum = (a_first_reg ? '0 : {1'b0, distance_reg})
                 + (DIST_W+1)'(diff);
        if (a_lastc_reg) begin
            distance_next      = dist_sum[DIST_W] ? DIST_MAX : dist_sum[DIST_W-1:0];
            running_count_next = '0;
        end else begin
            distance_next      = distance_reg;
            running_count_next = count;
        end
        exit_flag = a_lastc_reg && a_lasts_reg && (distance_next < exit_thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_count_reg <= '0;
            distance_reg      <= '0;
        end else if (a_adv) begin
            running_count_reg <= running_count_next;
            distance_reg      <= distance_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            m_spike_reg     <= upd.spike;
            m_count_reg     <= count;
            m_step_done_reg <= a_lastc_reg;
            m_seq_done_reg  <= a_lastc_reg && a_lasts_reg;
            m_exit_reg      <= exit_flag;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_spike         = m_spike_reg;
    assign m_step_count    = m_count_reg;
    assign m_step_done     = m_step_done_reg;
    assign m_sequence_done = m_seq_done_reg;
    assign m_exit_flag     = m_exit_reg;

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_ready)
        else $error("item accepted during membrane clearing");

    a_count_cleared_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_adv && a_lastc_reg) |=> (running_count_reg == '0))
        else $error("running count not cleared after step close");

    a_stage_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && m_valid_reg && !m_ready) |=> (a_valid_reg && $stable(a_addr_reg)))
        else $error("update stage lost its item under output stall");

    a_fwd_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        a_fwd_reg |-> (a_valid_reg && a_in_range_reg))
        else $error("forwarding flag without an in-range item");

    a_exit_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_exit_reg) |-> (m_seq_done_reg && m_step_done_reg))
        else $error("exit flag outside a sequence close");
`endif

endmodule

// ----- test/lifee_spike_checker.sv -----
// checker for the integrate-and-fire layer: predicts each result item and compares it
`timescale 1ns / 1ps

module lifee_spike_checker #(
    parameter int CHANNELS = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [lifee_pkg::IDX_W-1:0]         cfg_index,
    input  logic [lifee_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic signed [lifee_pkg::CUR_W-1:0]  s_current,
    input  logic [lifee_pkg::CH_W-1:0]          s_channel,
    input  logic                                s_first_step,
    input  logic                                s_last_channel,
    input  logic                                s_last_step,
    input  logic [lifee_pkg::CNT_W-1:0]         s_prev_count,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_spike,
    input  logic [lifee_pkg::CNT_W-1:0]         m_step_count,
    input  logic                                m_step_done,
    input  logic                                m_sequence_done,
    input  logic                                m_exit_flag,
    output int                                  fail_count,
    output int                                  pending
);
    import lifee_pkg::*;

    localparam longint MEM_HI = (longint'(1) << 23) - 1;
    localparam longint MEM_LO = -(longint'(1) << 23);

    typedef struct packed {
        logic             spike;
        logic [CNT_W-1:0] count;
        logic             step_done;
        logic             seq_done;
        logic             exit_flag;
    } spike_result_t;

    logic signed [MEM_W-1:0] membrane_mem [CHANNELS];
    logic [THR_W-1:0]        fire_thr;
    logic [LEAK_W-1:0]       leak_mul;
    logic [THR_W-1:0]        exit_thr;
    int unsigned             step_spikes;
    int unsigned             dist_total;
    spike_result_t           expected_q [$];

    task automatic report_bad(input string what, input int got, input int want);
        $display("%0t ns: %s is %0d, predicted %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic spike_result_t integrate_item(
        input logic signed [CUR_W-1:0] cur,
        input logic [CH_W-1:0]         ch,
        input logic                    first,
        input logic                    lastc,
        input logic                    lasts,
        input logic [CNT_W-1:0]        prev
    );
        spike_result_t res;
        longint        held;
        longint        level;
        int unsigned   cnt;
        int unsigned   diff;
        int unsigned   dist_acc;
        res = '0;
        held = (first || int'(ch) >= CHANNELS) ? 0 : longint'(membrane_mem[ch]);
        level = ((held * longint'(leak_mul)) >>> 16) + longint'(cur);
        if (level > MEM_HI) begin
            level = MEM_HI;
        end else if (level < MEM_LO) begin
            level = MEM_LO;
        end
        if (level > longint'(fire_thr)) begin
            level = level - longint'(fire_thr);
            res.spike = 1'b1;
        end
        if (int'(ch) < CHANNELS) begin
            membrane_mem[ch] = level[MEM_W-1:0];
        end
        cnt = step_spikes + res.spike;
        if (cnt > CNT_MAX) begin
            cnt = CNT_MAX;
        end
        if (lastc) begin
            diff = (cnt >= prev) ? cnt - prev : prev - cnt;
            dist_acc = first ? diff : dist_total + diff;
            if (dist_acc > DIST_MAX) begin
                dist_acc = DIST_MAX;
            end
            dist_total = dist_acc;
            step_spikes = 0;
            if (lasts) begin
                res.seq_done = 1'b1;
                res.exit_flag = dist_total < exit_thr;
            end
        end else begin
            step_spikes = cnt;
        end
        res.count = cnt[CNT_W-1:0];
        res.step_done = lastc;
        return res;
    endfunction

    always @(posedge aclk) begin
        spike_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                membrane_mem[i] = '0;
            end
            fire_thr = FIRE_THR_RST;
            leak_mul = LEAK_RST;
            exit_thr = EXIT_THR_RST;
            step_spikes = 0;
            dist_total = 0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_bad("unexpected result item, step_count", m_step_count, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_spike !== want.spike)
                        report_bad("spike", m_spike, want.spike);
                    if (m_step_count !== want.count)
                        report_bad("step_count", m_step_count, want.count);
                    if (m_step_done !== want.step_done)
                        report_bad("step_done", m_step_done, want.step_done);
                    if (m_sequence_done !== want.seq_done)
                        report_bad("sequence_done", m_sequence_done, want.seq_done);
                    if (m_exit_flag !== want.exit_flag)
                        report_bad("exit_flag", m_exit_flag, want.exit_flag);
                end
            end
            if (s_valid && s_ready) begin
                expected_q.push_back(integrate_item(s_current, s_channel, s_first_step,
                                                    s_last_channel, s_last_step,
                                                    s_prev_count));
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FIRE_THR: begin
                        fire_thr = cfg_wr_data[THR_W-1:0];
                    end
                    REG_LEAK: begin
                        leak_mul = cfg_wr_data[LEAK_W-1:0];
                    end
                    REG_EXIT_THR: begin
                        exit_thr = cfg_wr_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending <= expected_q.size();
    end

endmodule

// ----- test/tb_lif_neuron_layer_early_exit_top.sv -----
// testbench top for the integrate-and-fire layer: stimulus, configuration and verdict
`timescale 1ns / 1ps

module tb_lif_neuron_layer_early_exit_top;
    import lifee_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE   = 2'd3;
    localparam int               STALL_LIMIT = 5000;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]        cfg_index = '0;
    logic [CFG_W-1:0]        cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [CUR_W-1:0] s_current = '0;
    logic [CH_W-1:0]         s_channel = '0;
    logic                    s_first_step = 1'b0;
    logic                    s_last_channel = 1'b0;
    logic                    s_last_step = 1'b0;
    logic [CNT_W-1:0]        s_prev_count = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_spike;
    logic [CNT_W-1:0]        m_step_count;
    logic                    m_step_done;
    logic                    m_sequence_done;
    logic                    m_exit_flag;

    int fail_count;
    int pending;
    int items_sent = 0;
    int idle_cycles = 0;
    int ready_hold = 0;
    int fire_level = 128;
    bit steady = 1'b0;

    lif_neuron_layer_early_exit_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_current       (s_current),
        .s_channel       (s_channel),
        .s_first_step    (s_first_step),
        .s_last_channel  (s_last_channel),
        .s_last_step     (s_last_step),
        .s_prev_count    (s_prev_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_spike         (m_spike),
        .m_step_count    (m_step_count),
        .m_step_done     (m_step_done),
        .m_sequence_done (m_sequence_done),
        .m_exit_flag     (m_exit_flag)
    );

    lifee_spike_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_current       (s_current),
        .s_channel       (s_channel),
        .s_first_step    (s_first_step),
        .s_last_channel  (s_last_channel),
        .s_last_step     (s_last_step),
        .s_prev_count    (s_prev_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_spike         (m_spike),
        .m_step_count    (m_step_count),
        .m_step_done     (m_step_done),
        .m_sequence_done (m_sequence_done),
        .m_exit_flag     (m_exit_flag),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [CUR_W-1:0] pick_current();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if (r <= 3)
            return CUR_W'($urandom);
        if (r <= 6)
            return CUR_W'(fire_level / 2 + $urandom_range(0, fire_level + 64));
        return CUR_W'($urandom_range(0, 1024) - 256);
    endfunction

    function automatic logic [CNT_W-1:0] pick_prev(input int nch);
        if ($urandom_range(0, 4) == 0)
            return CNT_W'($urandom_range(0, 256));
        return CNT_W'($urandom_range(0, nch));
    endfunction

    // result side: random stalls, with long stretches of steady ready
    always @(posedge aclk) begin
        int stall;
        if (ready_hold != 0) begin
            ready_hold = ready_hold - 1;
        end else if (m_ready) begin
            stall = pick_gap();
            if (stall != 0) begin
                m_ready <= 1'b0;
                ready_hold = stall - 1;
            end else begin
                ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                          : $urandom_range(0, 4);
            end
        end else begin
            m_ready <= 1'b1;
            ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(0, 4);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("lif_neuron_layer_early_exit_top: mismatch");
                $finish;
            end
        end
    end

    task automatic send_item(
        input logic signed [CUR_W-1:0] cur,
        input logic [CH_W-1:0]         ch,
        input logic                    first,
        input logic                    lastc,
        input logic                    lasts,
        input logic [CNT_W-1:0]        prev
    );
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_current      <= cur;
        s_channel      <= ch;
        s_first_step   <= first;
        s_last_channel <= lastc;
        s_last_step    <= lasts;
        s_prev_count   <= prev;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
    endtask

    task automatic set_config(
        input logic [CFG_W-1:0] thr,
        input logic [CFG_W-1:0] leak,
        input logic [CFG_W-1:0] ext
    );
        drain();
        write_reg(REG_SPARE, CFG_W'($urandom));
        write_reg(REG_FIRE_THR, thr);
        write_reg(REG_LEAK, leak);
        write_reg(REG_EXIT_THR, ext);
        cfg_wr_en <= 1'b0;
        fire_level = int'(thr[THR_W-1:0]);
    endtask

    task automatic random_sequences(input int budget);
        int   start;
        int   nsteps;
        int   nch;
        int   base;
        int   s;
        int   c;
        logic first;
        logic lastc;
        start = items_sent;
        while (items_sent - start < budget) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 8)) begin
                    send_item(CUR_W'($urandom), CH_W'($urandom), 1'($urandom),
                              1'($urandom), 1'($urandom), CNT_W'($urandom));
                end
            end else begin
                nsteps = $urandom_range(1, 6);
                nch = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                base = $urandom_range(0, 256 - nch);
                for (s = 0; s < nsteps; s++) begin
                    for (c = 0; c < nch; c++) begin
                        first = (s == 0);
                        lastc = (c == nch - 1);
                        // occasionally break the framing
                        if ($urandom_range(0, 39) == 0)
                            first = !first;
                        if ($urandom_range(0, 39) == 0)
                            lastc = !lastc;
                        send_item(pick_current(), CH_W'(base + c), first, lastc,
                                  s == nsteps - 1, pick_prev(nch));
                    end
                end
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        int k;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset configuration
        send_item(16'sh7FFF, 8'd0,   1'b1, 1'b0, 1'b0, 9'd0);
        send_item(16'sh8000, 8'd1,   1'b1, 1'b0, 1'b0, 9'd0);
        send_item(16'sh0000, 8'd2,   1'b1, 1'b0, 1'b0, 9'd0);
        send_item(16'sd129,  8'd255, 1'b1, 1'b1, 1'b0, 9'd0);
        send_item(16'sd128,  8'd0,   1'b0, 1'b0, 1'b0, 9'd0);
        send_item(-16'sd1,   8'd1,   1'b0, 1'b0, 1'b0, 9'd0);
        send_item(16'sd1,    8'd2,   1'b0, 1'b0, 1'b0, 9'd0);
        send_item(16'sh7FFF, 8'd255, 1'b0, 1'b1, 1'b0, 9'd256);
        // last step flag without the closing channel
        send_item(16'sd100,  8'd3,   1'b0, 1'b0, 1'b1, 9'd0);
        send_item(16'sh7FFF, 8'd0,   1'b0, 1'b0, 1'b1, 9'd0);
        send_item(16'sh8000, 8'd1,   1'b0, 1'b0, 1'b1, 9'd0);
        send_item(16'sd300,  8'd2,   1'b0, 1'b0, 1'b1, 9'd0);
        send_item(16'sd200,  8'd255, 1'b0, 1'b1, 1'b1, 9'd511);
        send_item(16'sd200,  8'd4,   1'b1, 1'b1, 1'b1, 9'd1);
        send_item(16'sd50,   8'd5,   1'b1, 1'b1, 1'b1, 9'd0);

        // zero threshold, zero leak factor: spike count saturates within one long step
        set_config(16'h0000, 16'h0000, 16'h7FFF);
        for (k = 0; k < 520; k++) begin
            send_item(CUR_W'($urandom_range(1, 32767)), CH_W'(k), 1'b1, k == 519,
                      k == 519, 9'd0);
        end
        random_sequences(50);

        // widest threshold and leak: membrane keeps falling and distance saturates
        set_config(16'hFFFF, 16'hFFFF, 16'h0000);
        for (k = 0; k < 160; k++) begin
            send_item(16'sh8000, 8'd7, k == 0, 1'b1, k == 159, 9'd256);
        end
        random_sequences(50);

        for (k = 0; k < 4; k++) begin
            set_config($urandom_range(0, 1) ? CFG_W'($urandom_range(1, 1024))
                                            : CFG_W'($urandom),
                       CFG_W'($urandom),
                       $urandom_range(0, 3) != 0 ? CFG_W'($urandom_range(0, 300))
                                                 : CFG_W'($urandom));
            random_sequences(40);
        end

        drain();
        if (fail_count == 0) begin
            $display("lif_neuron_layer_early_exit_top: match");
        end else begin
            $display("lif_neuron_layer_early_exit_top: mismatch");
        end
        $finish;
    end

endmodule
